>>> rtl/efr_pkg.sv
`timescale 1ns / 1ps

package efr_pkg;

  localparam logic [7:0] ESC_BYTE        = 8'hFD;
  localparam logic [7:0] START_MARK      = 8'hFF;
  localparam logic [7:0] END_MARK        = 8'hFE;
  localparam logic [7:0] ESC_CODE_FF     = 8'h00;
  localparam logic [7:0] ESC_CODE_FE     = 8'h01;
  localparam logic [7:0] ESC_CODE_FD     = 8'h02;
  localparam int         MIN_RAW_LEN     = 40;
  localparam int         PAYLOAD_START   = 38;
  localparam int         LEN_LOW_INDEX   = 36;
  localparam int         LEN_HIGH_INDEX  = 37;
  localparam int         TRAILER_LEN     = 2;
  localparam int         EFR_QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_MARK     = 3'd2,
    ST_ESCAPE   = 3'd3,
    ST_CHECKSUM = 3'd4,
    ST_OVERRUN  = 3'd5
  } status_t;

  typedef struct packed {
    logic       has_payload;
    logic [7:0] payload;
    logic       has_status;
    status_t    status;
  } frame_entry_t;

endpackage

>>> rtl/efr_in_if.sv
`timescale 1ns / 1ps

interface efr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] raw_byte;
  logic       frame_end;

  modport source (output valid, output raw_byte, output frame_end, input ready);
  modport sink (input valid, input raw_byte, input frame_end, output ready);
endinterface

>>> rtl/efr_out_if.sv
`timescale 1ns / 1ps

interface efr_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] payload_byte;
  logic [2:0] status;
  logic       last;

  modport source (output valid, output kind, output payload_byte, output status,
                  output last, input ready);
  modport sink (input valid, input kind, input payload_byte, input status,
                input last, output ready);
endinterface

>>> rtl/escaped_frame_receiver.sv
`timescale 1ns / 1ps

// Port  Direction  Fields                               Handshake
// rx    sink       raw_byte[7:0], frame_end             valid/ready
// res   source     kind, payload_byte[7:0], status[2:0], last   valid/ready
//
// One raw byte is taken every cycle while the result queue has room.
// A byte is decoded in the cycle after its transfer and its results enter the queue then.
// A frame's closing byte can give a payload byte and the status, which leave in two transfers.
// The synchronous reset clears the frame state and empties the result queue.
// A stalled output fills the queue, and rx.ready falls once it cannot hold another byte.

module escaped_frame_receiver
  import efr_pkg::*;
#(
  parameter int QUEUE_DEPTH = EFR_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  efr_in_if.sink    rx,
  efr_out_if.source res
);

  logic         take;
  logic         busy;
  logic         entry_valid;
  frame_entry_t entry;
  logic         can_take;
  status_t      res_status;

  assign rx.ready = can_take;
  assign take     = rx.valid && can_take;

  efr_decoder u_decoder (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .raw_byte    (rx.raw_byte),
    .frame_end   (rx.frame_end),
    .busy        (busy),
    .entry_valid (entry_valid),
    .entry       (entry)
  );

  efr_result_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (entry_valid),
    .push_entry  (entry),
    .inflight    (busy),
    .can_take    (can_take),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .out_kind    (res.kind),
    .out_payload (res.payload_byte),
    .out_status  (res_status),
    .out_last    (res.last)
  );

  assign res.status = res_status;

endmodule

>>> rtl/efr_decoder.sv
`timescale 1ns / 1ps

module efr_decoder
  import efr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         take,
  input  logic [7:0]   raw_byte,
  input  logic         frame_end,
  output logic         busy,
  output logic         entry_valid,
  output frame_entry_t entry
);

  localparam logic [5:0]  RAW_SAT    = 6'(MIN_RAW_LEN);
  localparam logic [15:0] EMIT_FIRST = 16'(PAYLOAD_START + TRAILER_LEN);
  localparam logic [15:0] IDX_LEN_LO = 16'(LEN_LOW_INDEX);
  localparam logic [15:0] IDX_LEN_HI = 16'(LEN_HIGH_INDEX);
  localparam logic [15:0] IDX_MIN    = 16'(PAYLOAD_START);
  localparam logic [16:0] LEN_EXTRA  = 17'(PAYLOAD_START + TRAILER_LEN);

  logic        s1_valid;
  logic [7:0]  s1_raw;
  logic        s1_end;

  logic        escape_pending, escape_pending_next;
  logic [5:0]  raw_count, raw_count_next;
  logic [15:0] unescaped_index, unescaped_index_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  delay_bytes [2];
  logic [7:0]  delay_bytes_next [2];
  logic [15:0] length_field, length_field_next;
  logic        start_mark_ok, start_mark_ok_next;
  logic        escape_error, escape_error_next;

  logic        have;
  logic [7:0]  ub;
  logic        emit;
  status_t     st;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= take;
    end
    if (take) begin
      s1_raw <= raw_byte;
      s1_end <= frame_end;
    end
  end

  always_comb begin
    escape_pending_next  = escape_pending;
    raw_count_next       = raw_count;
    unescaped_index_next = unescaped_index;
    running_xor_next     = running_xor;
    delay_bytes_next[0]  = delay_bytes[0];
    delay_bytes_next[1]  = delay_bytes[1];
    length_field_next    = length_field;
    start_mark_ok_next   = start_mark_ok;
    escape_error_next    = escape_error;
    have                 = 1'b0;
    ub                   = 8'h00;
    emit                 = 1'b0;
    st                   = ST_OK;

    if (s1_valid) begin
      if (raw_count == 6'd0) begin
        start_mark_ok_next = (s1_raw == START_MARK);
      end
      if (raw_count < RAW_SAT) begin
        raw_count_next = raw_count + 6'd1;
      end

      if (escape_pending) begin
        escape_pending_next = 1'b0;
        case (s1_raw)
          ESC_CODE_FF: begin
            ub   = START_MARK;
            have = 1'b1;
          end
          ESC_CODE_FE: begin
            ub   = END_MARK;
            have = 1'b1;
          end
          ESC_CODE_FD: begin
            ub   = ESC_BYTE;
            have = 1'b1;
          end
          default: begin
            escape_error_next = 1'b1;
          end
        endcase
      end else if (s1_raw == ESC_BYTE) begin
        if (s1_end) begin
          escape_error_next = 1'b1;
        end else begin
          escape_pending_next = 1'b1;
        end
      end else begin
        ub   = s1_raw;
        have = 1'b1;
      end

      if (have) begin
        emit = (unescaped_index >= EMIT_FIRST) && (unescaped_index != 16'hFFFF) &&
               !length_field[15] && ((unescaped_index - EMIT_FIRST) < length_field);
        if (unescaped_index != 16'd0) begin
          running_xor_next = running_xor ^ ub;
        end
        if (unescaped_index == IDX_LEN_LO) begin
          length_field_next[7:0] = ub;
        end else if (unescaped_index == IDX_LEN_HI) begin
          length_field_next[15:8] = ub;
        end
        delay_bytes_next[1] = delay_bytes[0];
        delay_bytes_next[0] = ub;
        if (unescaped_index != 16'hFFFF) begin
          unescaped_index_next = unescaped_index + 16'd1;
        end
      end

      if (s1_end) begin
        if (raw_count_next < RAW_SAT) begin
          st = ST_SHORT;
        end else if (!start_mark_ok_next || (s1_raw != END_MARK)) begin
          st = ST_MARK;
        end else if (escape_error_next) begin
          st = ST_ESCAPE;
        end else if (running_xor != 8'h00) begin
          st = ST_CHECKSUM;
        end else if (unescaped_index_next < IDX_MIN) begin
          st = ST_OVERRUN;
        end else if (!length_field_next[15] &&
                     (({1'b0, length_field_next} + LEN_EXTRA) >
                      {1'b0, unescaped_index_next})) begin
          st = ST_OVERRUN;
        end else begin
          st = ST_OK;
        end
        escape_pending_next  = 1'b0;
        raw_count_next       = 6'd0;
        unescaped_index_next = 16'd0;
        running_xor_next     = 8'h00;
        delay_bytes_next[0]  = 8'h00;
        delay_bytes_next[1]  = 8'h00;
        length_field_next    = 16'd0;
        start_mark_ok_next   = 1'b0;
        escape_error_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending  <= 1'b0;
      raw_count       <= 6'd0;
      unescaped_index <= 16'd0;
      running_xor     <= 8'h00;
      delay_bytes[0]  <= 8'h00;
      delay_bytes[1]  <= 8'h00;
      length_field    <= 16'd0;
      start_mark_ok   <= 1'b0;
      escape_error    <= 1'b0;
    end else begin
      escape_pending  <= escape_pending_next;
      raw_count       <= raw_count_next;
      unescaped_index <= unescaped_index_next;
      running_xor     <= running_xor_next;
      delay_bytes[0]  <= delay_bytes_next[0];
      delay_bytes[1]  <= delay_bytes_next[1];
      length_field    <= length_field_next;
      start_mark_ok   <= start_mark_ok_next;
      escape_error    <= escape_error_next;
    end
  end

  assign busy               = s1_valid;
  assign entry_valid        = s1_valid && (emit || s1_end);
  assign entry.has_payload  = emit;
  assign entry.payload      = delay_bytes[1];
  assign entry.has_status   = s1_valid && s1_end;
  assign entry.status       = st;

  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_end) |=> (raw_count == 6'd0 && unescaped_index == 16'd0 &&
                              !escape_pending && !escape_error))
    else $error("frame state not cleared after the closing byte");

  a_raw_count_sat: assert property (@(posedge clk) disable iff (rst)
    raw_count <= RAW_SAT)
    else $error("raw byte count past its saturation value");

  a_emit_in_payload: assert property (@(posedge clk) disable iff (rst)
    (entry_valid && entry.has_payload) |-> (unescaped_index >= EMIT_FIRST))
    else $error("payload byte emitted before the payload area");

endmodule

>>> rtl/efr_result_queue.sv
`timescale 1ns / 1ps

module efr_result_queue
  import efr_pkg::*;
#(
  parameter int DEPTH = EFR_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  frame_entry_t push_entry,
  input  logic         inflight,
  output logic         can_take,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         out_kind,
  output logic [7:0]   out_payload,
  output status_t      out_status,
  output logic         out_last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  frame_entry_t   entries [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [CW-1:0]  count, count_next;
  logic           payload_sent;
  frame_entry_t   head;
  logic           show_payload;
  logic           xfer;
  logic           pop;
  logic [CW:0]    fill_sum;

  assign head         = entries[rd_ptr];
  assign out_valid    = (count != '0);
  assign show_payload = head.has_payload && !payload_sent;
  assign out_kind     = !show_payload;
  assign out_payload  = show_payload ? head.payload : 8'h00;
  assign out_status   = show_payload ? ST_OK : head.status;
  assign out_last     = !show_payload;
  assign xfer         = out_valid && out_ready;
  assign pop          = xfer && (!show_payload || !head.has_status);

  assign fill_sum = {1'b0, count} + {{CW{1'b0}}, inflight};
  assign can_take = fill_sum < (CW + 1)'(DEPTH);

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (!push && pop) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
      payload_sent <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr       <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
        payload_sent <= 1'b0;
      end else if (xfer) begin
        payload_sent <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue count beyond its depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < CW'(DEPTH)) || pop)
    else $error("result queue written while full");

  a_split_order: assert property (@(posedge clk) disable iff (rst)
    payload_sent |-> (out_valid && head.has_status && head.has_payload))
    else $error("split entry lost its status half");

endmodule

>>> sim/escaped_frame_receiver_tb.sv
`timescale 1ns / 1ps

module escaped_frame_receiver_tb;
  import efr_pkg::*;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam int INDEX_LIMIT = 65535;
  localparam int RANDOM_ITEMS = 1900;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload;
    status_t    status;
    logic       last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst;

  efr_in_if rx_bus ();
  efr_out_if res_bus ();

  escaped_frame_receiver dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_bus),
    .res(res_bus)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Deframer state as seen by the prediction.
  logic        esc_waiting;
  int unsigned raw_seen;
  int unsigned byte_index;
  logic [7:0]  sum_acc;
  logic [7:0]  newest_byte;
  logic [7:0]  older_byte;
  logic [15:0] length_word;
  logic        start_seen_ok;
  logic        escape_bad;

  frame_result_t awaited_results[$];
  logic [7:0]    frame_buf[$];
  logic [7:0]    wire_buf[$];

  bit idle_on = 1'b1;
  int errors = 0;
  int bytes_sent = 0;
  int payload_seen = 0;
  int status_seen[6];

  function automatic void add_awaited(input frame_result_t r);
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  function automatic void add_frame_byte(input logic [7:0] b);
    frame_buf.insert(frame_buf.size(), b);
  endfunction

  function automatic void add_wire_byte(input logic [7:0] b);
    wire_buf.insert(wire_buf.size(), b);
  endfunction

  function automatic int idle_draw();
    return idle_on ? $urandom_range(0, 12) : 0;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return ESC_BYTE;
      1: return START_MARK;
      2: return END_MARK;
      3: return ESC_CODE_FF + 8'($urandom_range(0, 2));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic clear_frame_state();
    esc_waiting = 1'b0;
    raw_seen = 0;
    byte_index = 0;
    sum_acc = 8'h00;
    newest_byte = 8'h00;
    older_byte = 8'h00;
    length_word = 16'h0000;
    start_seen_ok = 1'b0;
    escape_bad = 1'b0;
  endtask

  task automatic deframe_byte(input logic [7:0] raw, input logic at_end);
    logic          have;
    logic [7:0]    ub;
    logic [7:0]    sum_prev;
    frame_result_t r;
    have = 1'b0;
    ub = 8'h00;
    if (raw_seen == 0) start_seen_ok = (raw == START_MARK);
    if (raw_seen < MIN_RAW_LEN) raw_seen++;
    if (esc_waiting) begin
      esc_waiting = 1'b0;
      case (raw)
        ESC_CODE_FF: begin ub = START_MARK; have = 1'b1; end
        ESC_CODE_FE: begin ub = END_MARK; have = 1'b1; end
        ESC_CODE_FD: begin ub = ESC_BYTE; have = 1'b1; end
        default: escape_bad = 1'b1;
      endcase
    end else if (raw == ESC_BYTE) begin
      if (at_end) escape_bad = 1'b1;
      else esc_waiting = 1'b1;
    end else begin
      ub = raw;
      have = 1'b1;
    end
    sum_prev = sum_acc;
    if (have) begin
      // Two later bytes prove that the delayed byte is payload.
      if (byte_index >= PAYLOAD_START + TRAILER_LEN && byte_index < INDEX_LIMIT &&
          !length_word[15] &&
          (byte_index - (PAYLOAD_START + TRAILER_LEN)) < int'(length_word)) begin
        r.kind = KIND_PAYLOAD;
        r.payload = older_byte;
        r.status = ST_OK;
        r.last = 1'b0;
        add_awaited(r);
      end
      if (byte_index >= 1) sum_acc ^= ub;
      if (byte_index == LEN_LOW_INDEX) length_word[7:0] = ub;
      else if (byte_index == LEN_HIGH_INDEX) length_word[15:8] = ub;
      older_byte = newest_byte;
      newest_byte = ub;
      if (byte_index < INDEX_LIMIT) byte_index++;
    end
    if (at_end) begin
      r.kind = KIND_STATUS;
      r.payload = 8'h00;
      r.last = 1'b1;
      if (raw_seen < MIN_RAW_LEN) r.status = ST_SHORT;
      else if (!start_seen_ok || raw != END_MARK) r.status = ST_MARK;
      else if (escape_bad) r.status = ST_ESCAPE;
      else if (sum_prev != 8'h00) r.status = ST_CHECKSUM;
      else if (byte_index < PAYLOAD_START) r.status = ST_OVERRUN;
      else if (!length_word[15] &&
               PAYLOAD_START + int'(length_word) + TRAILER_LEN > byte_index)
        r.status = ST_OVERRUN;
      else r.status = ST_OK;
      add_awaited(r);
      clear_frame_state();
    end
  endtask

  task automatic push_raw_byte(input logic [7:0] b, input logic at_end);
    int gap;
    gap = idle_draw();
    if (gap > 0) begin
      rx_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_bus.valid <= 1'b1;
    rx_bus.raw_byte <= b;
    rx_bus.frame_end <= at_end;
    do @(posedge clk); while (!rx_bus.ready);
    deframe_byte(b, at_end);
    bytes_sent++;
  endtask

  task automatic hold_until_drained();
    rx_bus.valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  task automatic build_frame(input int plen, input logic [15:0] len_val, input bit sum_ok);
    logic [7:0] acc;
    frame_buf.delete();
    add_frame_byte(START_MARK);
    for (int i = 1; i < LEN_LOW_INDEX; i++) add_frame_byte(rand_byte());
    add_frame_byte(len_val[7:0]);
    add_frame_byte(len_val[15:8]);
    for (int i = 0; i < plen; i++) add_frame_byte(rand_byte());
    acc = 8'h00;
    for (int i = 1; i < frame_buf.size(); i++) acc ^= frame_buf[i];
    add_frame_byte(sum_ok ? acc : acc ^ (8'h01 << $urandom_range(0, 7)));
    add_frame_byte(END_MARK);
  endtask

  // Marks stay raw; 0xFD is always escaped, 0xFF and 0xFE always with esc_all, else at random.
  task automatic encode_frame(input bit esc_all);
    int last_i;
    last_i = frame_buf.size() - 1;
    wire_buf.delete();
    for (int i = 0; i <= last_i; i++) begin
      if (i == 0 || i == last_i) begin
        add_wire_byte(frame_buf[i]);
      end else if (frame_buf[i] == ESC_BYTE) begin
        add_wire_byte(ESC_BYTE);
        add_wire_byte(ESC_CODE_FD);
      end else if (frame_buf[i] == START_MARK && (esc_all || $urandom_range(0, 1))) begin
        add_wire_byte(ESC_BYTE);
        add_wire_byte(ESC_CODE_FF);
      end else if (frame_buf[i] == END_MARK && (esc_all || $urandom_range(0, 1))) begin
        add_wire_byte(ESC_BYTE);
        add_wire_byte(ESC_CODE_FE);
      end else begin
        add_wire_byte(frame_buf[i]);
      end
    end
  endtask

  task automatic send_wire(input int from_i, input int to_i);
    for (int i = from_i; i <= to_i; i++) push_raw_byte(wire_buf[i], i == wire_buf.size() - 1);
  endtask

  task automatic send_frame(input int plen, input logic [15:0] len_val, input bit sum_ok);
    build_frame(plen, len_val, sum_ok);
    encode_frame($urandom_range(0, 3) == 0);
    send_wire(0, wire_buf.size() - 1);
  endtask

  task automatic send_short(input int n);
    wire_buf.delete();
    if (n > 1) add_wire_byte(START_MARK);
    for (int i = 2; i < n; i++) add_wire_byte(rand_byte());
    add_wire_byte(END_MARK);
    send_wire(0, wire_buf.size() - 1);
  endtask

  task automatic send_bad_escape(input int plen);
    int pos;
    build_frame(plen, 16'(plen), 1'b1);
    encode_frame(1'b0);
    pos = $urandom_range(1, wire_buf.size() - 2);
    wire_buf.insert(pos, ESC_BYTE);
    wire_buf.insert(pos + 1, 8'($urandom_range(3, 255)));
    send_wire(0, wire_buf.size() - 1);
  endtask

  task automatic send_bad_mark(input bit at_start);
    logic [7:0] v;
    build_frame($urandom_range(0, 8), 16'h0000, 1'b1);
    if (at_start) begin
      v = 8'($urandom_range(0, 254));
      frame_buf[0] = v;
    end else begin
      do v = 8'($urandom); while (v == END_MARK);
      frame_buf[frame_buf.size() - 1] = v;
    end
    encode_frame(1'b0);
    send_wire(0, wire_buf.size() - 1);
  endtask

  task automatic test_clean_frames();
    logic [7:0] fix;
    idle_on = 1'b1;
    build_frame(0, 16'h0000, 1'b1);
    // The checksum byte absorbs the change of the first two header bytes.
    fix = frame_buf[1] ^ frame_buf[2] ^ 8'hFF;
    frame_buf[1] = 8'h00;
    frame_buf[2] = 8'hFF;
    frame_buf[frame_buf.size() - 2] ^= fix;
    encode_frame(1'b1);
    send_wire(0, wire_buf.size() - 1);
    send_frame(3, 16'd3, 1'b1);
    build_frame(6, 16'd6, 1'b1);
    encode_frame(1'b1);
    send_wire(0, wire_buf.size() - 1);
  endtask

  task automatic test_length_field();
    send_frame(2, 16'h8000, 1'b1);
    send_frame(0, 16'hFFFF, 1'b1);
    send_frame(2, 16'd3, 1'b1);
    send_frame(1, 16'h7FFF, 1'b1);
    // Enough escapes leave fewer unescaped bytes than the header needs.
    frame_buf.delete();
    for (int i = 0; i < 21; i++) add_frame_byte(START_MARK);
    add_frame_byte(END_MARK);
    encode_frame(1'b1);
    send_wire(0, wire_buf.size() - 1);
  endtask

  task automatic test_status_checks();
    send_short(1);
    send_short(MIN_RAW_LEN - 1);
    send_bad_mark(1'b1);
    send_bad_mark(1'b0);
    build_frame(1, 16'd1, 1'b1);
    frame_buf[frame_buf.size() - 1] = ESC_BYTE;
    encode_frame(1'b0);
    send_wire(0, wire_buf.size() - 1);
    send_bad_escape(2);
    send_frame(2, 16'd2, 1'b0);
  endtask

  task automatic test_drain_pause();
    int half;
    build_frame(10, 16'd10, 1'b1);
    encode_frame(1'b0);
    half = wire_buf.size() - 4;
    send_wire(0, half);
    hold_until_drained();
    send_wire(half + 1, wire_buf.size() - 1);
    hold_until_drained();
  endtask

  task automatic test_random_frames();
    int pick;
    int plen;
    while (bytes_sent < RANDOM_ITEMS) begin
      idle_on = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 150) : $urandom_range(0, 24);
      if (pick < 60) begin
        if ($urandom_range(0, 7) == 0) send_frame(plen, 16'h8000 | 16'($urandom), 1'b1);
        else send_frame(plen, 16'(plen), 1'b1);
      end else if (pick < 68) begin
        send_frame(plen, 16'(plen), 1'b0);
      end else if (pick < 75) begin
        send_bad_escape(plen);
      end else if (pick < 82) begin
        if ($urandom_range(0, 1)) send_frame(plen, 16'(plen + $urandom_range(1, 4)), 1'b1);
        else send_frame(plen, 16'($urandom_range(0, 32767)), 1'b1);
      end else if (pick < 88) begin
        send_bad_mark($urandom_range(0, 1));
      end else if (pick < 93) begin
        send_short($urandom_range(1, MIN_RAW_LEN - 1));
      end else begin
        wire_buf.delete();
        repeat ($urandom_range(20, 60)) add_wire_byte(8'($urandom));
        send_wire(0, wire_buf.size() - 1);
      end
      if ($urandom_range(0, 9) == 0) hold_until_drained();
    end
    idle_on = 1'b1;
  endtask

  initial begin : result_checker
    int stall;
    frame_result_t exp_r;
    stall = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_bus.valid && res_bus.ready) begin
        if (res_bus.kind == KIND_PAYLOAD) payload_seen++;
        else if (res_bus.status < 6) status_seen[res_bus.status]++;
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: kind %0d byte %02h status %0d last %0d", $time,
                   res_bus.kind, res_bus.payload_byte, res_bus.status, res_bus.last);
        end else begin
          exp_r = awaited_results.pop_front();
          if (res_bus.kind !== exp_r.kind) begin
            errors++;
            $display("%0t: kind expected %0d actual %0d", $time, exp_r.kind, res_bus.kind);
          end
          if (res_bus.payload_byte !== exp_r.payload) begin
            errors++;
            $display("%0t: payload_byte expected %02h actual %02h", $time, exp_r.payload,
                     res_bus.payload_byte);
          end
          if (res_bus.status !== exp_r.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     res_bus.status);
          end
          if (res_bus.last !== exp_r.last) begin
            errors++;
            $display("%0t: last expected %0d actual %0d", $time, exp_r.last, res_bus.last);
          end
        end
        stall = idle_draw();
      end
      if (rst) begin
        res_bus.ready <= 1'b0;
      end else if (stall > 0) begin
        res_bus.ready <= 1'b0;
        stall--;
      end else begin
        res_bus.ready <= 1'b1;
      end
    end
  end

  initial begin
    #4000000;
    $display("escaped_frame_receiver: mismatch");
    $finish;
  end

  initial begin
    clear_frame_state();
    foreach (status_seen[i]) status_seen[i] = 0;
    rst <= 1'b1;
    rx_bus.valid <= 1'b0;
    rx_bus.raw_byte <= 8'h00;
    rx_bus.frame_end <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_clean_frames();
    test_length_field();
    test_status_checks();
    test_drain_pause();
    test_random_frames();
    rx_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("Sent %0d raw bytes and checked %0d provisional payload bytes.", bytes_sent,
             payload_seen);
    $display("Frame status counts (ok/short/mark/escape/checksum/overrun): %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2]);
    $display("  followed by %0d %0d %0d.", status_seen[3], status_seen[4], status_seen[5]);
    if (errors == 0) begin
      $display("escaped_frame_receiver: match");
    end else begin
      $display("escaped_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule

>>> escaped_frame_receiver.f
rtl/efr_pkg.sv
rtl/efr_in_if.sv
rtl/efr_out_if.sv
rtl/efr_decoder.sv
rtl/efr_result_queue.sv
rtl/escaped_frame_receiver.sv
sim/escaped_frame_receiver_tb.sv
